// ----- design/xcfr_pkg.sv -----
// Package for the XOR-checked frame receiver.
// Holds result kinds, register indexes and framing constants; no dependencies.
`default_nettype none

package xcfr_pkg;

    localparam int unsigned BYTE_W = 8;

    // The frame length field counts eight bytes of framing beyond the payload.
    localparam logic [15:0] LENGTH_OVERHEAD = 16'd8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_GOOD      = 2'd1,
        KIND_MISMATCH  = 2'd2,
        KIND_LEN_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_MAX_PAYLOAD   = 2'd2
    } reg_index_t;

    localparam byte_t HEADER_FIRST_RESET  = 8'h00;
    localparam byte_t HEADER_SECOND_RESET = 8'h00;
    localparam byte_t MAX_PAYLOAD_RESET   = 8'hFF;

endpackage

`default_nettype wire

// ----- design/xor_checked_frame_receiver.sv -----
// Top level of the XOR-checked frame receiver: input word register, frame
// parser state and result register. Depends on xcfr_pkg.
`default_nettype none

// Usage
//   The input channel (in_valid, in_ready, rx_byte) carries one received
//   serial byte per word. The block hunts for a two-byte header, reads a
//   big-endian frame length, an opcode, the payload, a check byte and two
//   trailer bytes. Every payload byte produces one result word, and the
//   second trailer byte produces a frame status word (good or mismatch).
//   A bad frame length produces a length-error word and restarts the hunt.
//   Bytes that produce no result are consumed silently.
//   The configuration port (cfg_write, cfg_index, cfg_data) sets the two
//   header bytes and the largest accepted payload length; the user must
//   write it only while no bytes are in flight (not enforced by the block).
//   Writes to an unused index are ignored. An accepted byte is parsed, and
//   its word presented, once the result register is free or being emptied.
//   Throughput: one byte per cycle while out_ready is high. The parser state
//   updates per byte, so the only limit is the one-entry result register.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_ready then drops until out_ready returns.
//   Reset clears the parser to header hunting, empties both registers and
//   restores the configuration defaults.
module xor_checked_frame_receiver
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire xcfr_pkg::byte_t      cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire xcfr_pkg::byte_t      rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                kind,
    output xcfr_pkg::byte_t           byte_value,
    output xcfr_pkg::byte_t           byte_index,
    output xcfr_pkg::byte_t           opcode,
    output xcfr_pkg::byte_t           payload_length,
    output xcfr_pkg::byte_t           received_check,
    output xcfr_pkg::byte_t           computed_check
);

    import xcfr_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT1   = 4'd0,
        PH_HUNT2   = 4'd1,
        PH_LENHI   = 4'd2,
        PH_LENLO   = 4'd3,
        PH_OPCODE  = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CHECK   = 4'd6,
        PH_TRAIL1  = 4'd7,
        PH_TRAIL2  = 4'd8
    } phase_t;

    // Configuration registers.
    byte_t header_first_reg;
    byte_t header_second_reg;
    byte_t max_payload_reg;

    // Input word register.
    logic  in_full_reg;
    byte_t in_byte_reg;

    // Frame parser state.
    phase_t phase_reg, phase_next;
    byte_t  length_high_reg, length_high_next;
    byte_t  plen_reg, plen_next;
    byte_t  count_reg, count_next;
    byte_t  check_run_reg, check_run_next;
    byte_t  opcode_reg, opcode_next;
    byte_t  check_byte_reg, check_byte_next;

    // Result register.
    logic  out_full_reg;
    kind_t kind_reg, kind_next;
    byte_t value_reg, value_next;
    byte_t index_reg, index_next;
    byte_t op_out_reg, op_out_next;
    byte_t plen_out_reg, plen_out_next;
    byte_t rchk_out_reg, rchk_out_next;
    byte_t cchk_out_reg, cchk_out_next;
    logic  emit;

    logic        advance;
    logic [15:0] frame_len;
    logic [15:0] frame_plen;
    logic        len_bad;
    byte_t       count_inc;
    byte_t       run_xor;

    // The parser consumes the held byte whenever the result slot is free or
    // being emptied this cycle.
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    assign frame_len  = {length_high_reg, in_byte_reg};
    assign frame_plen = frame_len - LENGTH_OVERHEAD;
    assign len_bad    = (frame_len < LENGTH_OVERHEAD)
                     || (frame_plen > {8'd0, max_payload_reg});
    assign count_inc  = count_reg + 8'd1;
    assign run_xor    = check_run_reg ^ in_byte_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        plen_next        = plen_reg;
        count_next       = count_reg;
        check_run_next   = check_run_reg;
        opcode_next      = opcode_reg;
        check_byte_next  = check_byte_reg;
        emit             = 1'b0;
        kind_next        = KIND_PAYLOAD;
        value_next       = '0;
        index_next       = '0;
        op_out_next      = '0;
        plen_out_next    = '0;
        rchk_out_next    = '0;
        cchk_out_next    = '0;

        case (phase_reg)
            PH_HUNT2:
            begin
                // A wrong second byte is not retried as a first header byte.
                phase_next = (in_byte_reg == header_second_reg) ? PH_LENHI : PH_HUNT1;
            end
            PH_LENHI:
            begin
                length_high_next = in_byte_reg;
                phase_next       = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (len_bad)
                begin
                    phase_next = PH_HUNT1;
                    emit       = 1'b1;
                    kind_next  = KIND_LEN_ERROR;
                end
                else
                begin
                    plen_next      = frame_plen[7:0];
                    check_run_next = length_high_reg ^ in_byte_reg;
                    count_next     = '0;
                    phase_next     = PH_OPCODE;
                end
            end
            PH_OPCODE:
            begin
                opcode_next    = in_byte_reg;
                check_run_next = run_xor;
                phase_next     = (plen_reg == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                check_run_next = run_xor;
                count_next     = count_inc;
                if (count_inc >= plen_reg)
                begin
                    phase_next = PH_CHECK;
                end
                emit          = 1'b1;
                kind_next     = KIND_PAYLOAD;
                value_next    = in_byte_reg;
                index_next    = count_reg;
                op_out_next   = opcode_reg;
                plen_out_next = plen_reg;
                cchk_out_next = run_xor;
            end
            PH_CHECK:
            begin
                check_byte_next = in_byte_reg;
                phase_next      = PH_TRAIL1;
            end
            PH_TRAIL1:
            begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                phase_next    = PH_HUNT1;
                emit          = 1'b1;
                kind_next     = (check_run_reg == check_byte_reg) ? KIND_GOOD : KIND_MISMATCH;
                op_out_next   = opcode_reg;
                plen_out_next = plen_reg;
                rchk_out_next = check_byte_reg;
                cchk_out_next = check_run_reg;
            end
            default:
            begin
                // Hunting for the first header byte; unused codes land here too.
                phase_next = (in_byte_reg == header_first_reg) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            max_payload_reg   <= MAX_PAYLOAD_RESET;
            in_full_reg       <= 1'b0;
            in_byte_reg       <= '0;
            phase_reg         <= PH_HUNT1;
            length_high_reg   <= '0;
            plen_reg          <= '0;
            count_reg         <= '0;
            check_run_reg     <= '0;
            opcode_reg        <= '0;
            check_byte_reg    <= '0;
            out_full_reg      <= 1'b0;
            kind_reg          <= KIND_PAYLOAD;
            value_reg         <= '0;
            index_reg         <= '0;
            op_out_reg        <= '0;
            plen_out_reg      <= '0;
            rchk_out_reg      <= '0;
            cchk_out_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                    REG_HEADER_SECOND: header_second_reg <= cfg_data;
                    REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data;
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                in_full_reg <= 1'b1;
                in_byte_reg <= rx_byte;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg       <= phase_next;
                length_high_reg <= length_high_next;
                plen_reg        <= plen_next;
                count_reg       <= count_next;
                check_run_reg   <= check_run_next;
                opcode_reg      <= opcode_next;
                check_byte_reg  <= check_byte_next;
            end

            if (advance && emit)
            begin
                out_full_reg <= 1'b1;
                kind_reg     <= kind_next;
                value_reg    <= value_next;
                index_reg    <= index_next;
                op_out_reg   <= op_out_next;
                plen_out_reg <= plen_out_next;
                rchk_out_reg <= rchk_out_next;
                cchk_out_reg <= cchk_out_next;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_full_reg;
    assign kind           = kind_reg;
    assign byte_value     = value_reg;
    assign byte_index     = index_reg;
    assign opcode         = op_out_reg;
    assign payload_length = plen_out_reg;
    assign received_check = rchk_out_reg;
    assign computed_check = cchk_out_reg;

endmodule

`default_nettype wire

// ----- tb/xcfr_tb_pkg.sv -----
// Result word layout and frame scoreboard for the XOR-checked frame receiver bench.
// Depends on xcfr_pkg for the byte type, result kinds, register indexes and reset values.

package xcfr_tb_pkg;

    import xcfr_pkg::*;

    // The two-bit register index can also address a slot with no register behind it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        kind_t kind;
        byte_t byte_value;
        byte_t byte_index;
        byte_t opcode;
        byte_t payload_length;
        byte_t received_check;
        byte_t computed_check;
    } frame_result_t;

    typedef enum logic [3:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        LEN_HIGH,
        LEN_LOW,
        OPCODE_BYTE,
        PAYLOAD_BYTES,
        CHECK_BYTE,
        TRAILER_FIRST,
        TRAILER_SECOND
    } parse_phase_t;

    class frame_scoreboard;

        byte_t header_first;
        byte_t header_second;
        byte_t max_payload;

        parse_phase_t phase;
        byte_t length_high;
        byte_t frame_len;
        byte_t frame_count;
        byte_t xor_sum;
        byte_t frame_opcode;
        byte_t frame_check;

        frame_result_t results_due[$];
        int unsigned mismatches;
        int unsigned kind_total[4];

        function new();
            header_first  = HEADER_FIRST_RESET;
            header_second = HEADER_SECOND_RESET;
            max_payload   = MAX_PAYLOAD_RESET;
            phase         = SEEK_FIRST;
            length_high   = '0;
            frame_len     = '0;
            frame_count   = '0;
            xor_sum       = '0;
            frame_opcode  = '0;
            frame_check   = '0;
            mismatches    = 0;
        endfunction

        function void set_register(logic [1:0] index, byte_t value);
            case (index)
                REG_HEADER_FIRST:  header_first  = value;
                REG_HEADER_SECOND: header_second = value;
                REG_MAX_PAYLOAD:   max_payload   = value;
                default: ;
            endcase
        endfunction

        // Advances the frame parser by one accepted byte and queues the word it produces.
        function void parse_byte(byte_t b);
            logic [15:0] frame_length;
            frame_result_t r;
            bit emit;
            r = '0;
            emit = 1'b0;
            case (phase)
                SEEK_SECOND: phase = (b == header_second) ? LEN_HIGH : SEEK_FIRST;
                LEN_HIGH:
                begin
                    length_high = b;
                    phase = LEN_LOW;
                end
                LEN_LOW:
                begin
                    frame_length = {length_high, b};
                    if (frame_length < LENGTH_OVERHEAD
                        || frame_length - LENGTH_OVERHEAD > {8'd0, max_payload})
                    begin
                        r.kind = KIND_LEN_ERROR;
                        emit = 1'b1;
                        phase = SEEK_FIRST;
                    end
                    else
                    begin
                        frame_len = byte_t'(frame_length - LENGTH_OVERHEAD);
                        xor_sum = length_high ^ b;
                        frame_count = '0;
                        phase = OPCODE_BYTE;
                    end
                end
                OPCODE_BYTE:
                begin
                    frame_opcode = b;
                    xor_sum ^= b;
                    phase = (frame_len == 0) ? CHECK_BYTE : PAYLOAD_BYTES;
                end
                PAYLOAD_BYTES:
                begin
                    xor_sum ^= b;
                    r.kind = KIND_PAYLOAD;
                    r.byte_value = b;
                    r.byte_index = frame_count;
                    r.opcode = frame_opcode;
                    r.payload_length = frame_len;
                    r.computed_check = xor_sum;
                    emit = 1'b1;
                    frame_count++;
                    if (frame_count >= frame_len)
                        phase = CHECK_BYTE;
                end
                CHECK_BYTE:
                begin
                    frame_check = b;
                    phase = TRAILER_FIRST;
                end
                TRAILER_FIRST: phase = TRAILER_SECOND;
                TRAILER_SECOND:
                begin
                    r.kind = (xor_sum == frame_check) ? KIND_GOOD : KIND_MISMATCH;
                    r.opcode = frame_opcode;
                    r.payload_length = frame_len;
                    r.received_check = frame_check;
                    r.computed_check = xor_sum;
                    emit = 1'b1;
                    phase = SEEK_FIRST;
                end
                default: phase = (b == header_first) ? SEEK_SECOND : SEEK_FIRST;
            endcase
            if (emit)
            begin
                results_due.push_back(r);
                kind_total[r.kind]++;
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH %0d: %s", mismatches, msg);
        endtask

        task check_field(string name, byte_t got, byte_t want, kind_t want_kind);
            if (got !== want)
                report($sformatf("%s is 0x%02h, predicted 0x%02h (predicted word %s)",
                                 name, got, want, want_kind.name()));
        endtask

        task check_result(frame_result_t got);
            frame_result_t want;
            if (results_due.size() == 0)
            begin
                report($sformatf("result word of kind %0d arrived with none predicted",
                                 got.kind));
                return;
            end
            want = results_due.pop_front();
            check_field("kind", byte_t'(got.kind), byte_t'(want.kind), want.kind);
            check_field("byte_value", got.byte_value, want.byte_value, want.kind);
            check_field("byte_index", got.byte_index, want.byte_index, want.kind);
            check_field("opcode", got.opcode, want.opcode, want.kind);
            check_field("payload_length", got.payload_length, want.payload_length, want.kind);
            check_field("received_check", got.received_check, want.received_check, want.kind);
            check_field("computed_check", got.computed_check, want.computed_check, want.kind);
        endtask

        function int unsigned pending();
            return results_due.size();
        endfunction

    endclass

endpackage

// ----- tb/tb_xor_checked_frame_receiver.sv -----
// Top-level bench for xor_checked_frame_receiver: drives serial bytes and register writes,
// checks every result word against the frame scoreboard. Depends on xcfr_pkg and xcfr_tb_pkg.

module tb_xor_checked_frame_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    import xcfr_pkg::*;
    import xcfr_tb_pkg::*;

    // Bytes offered in the random part, spread over the register settings below.
    localparam int unsigned RANDOM_BYTES     = 780;
    localparam int unsigned SETTING_COUNT    = 6;
    // Edges waited after the last predicted word, so a byte that makes no word gets parsed.
    localparam int unsigned DRAIN_CYCLES     = 4;
    localparam int unsigned LONG_HOLD_CYCLES = 120;
    // Run limit in cycles, with ample margin over the slowest legal run.
    localparam int unsigned CYCLE_LIMIT      = 250_000;

    logic  clk;
    logic  rst_n;
    logic  cfg_write;
    logic  [1:0] cfg_index;
    byte_t cfg_data;
    logic  in_valid;
    logic  in_ready;
    byte_t rx_byte;
    logic  out_valid;
    logic  out_ready;
    logic  [1:0] kind;
    byte_t byte_value;
    byte_t byte_index;
    byte_t opcode;
    byte_t payload_length;
    byte_t received_check;
    byte_t computed_check;

    frame_scoreboard sb;
    frame_result_t   observed;

    // Largest gap either side may draw before its next word; zero gives back-to-back traffic.
    int unsigned idle_max = 10;
    bit          long_hold_request = 1'b0;
    int unsigned long_holds_done = 0;
    int unsigned bytes_sent = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned cycle_count = 0;

    xor_checked_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .byte_value     (byte_value),
        .byte_index     (byte_index),
        .opcode         (opcode),
        .payload_length (payload_length),
        .received_check (received_check),
        .computed_check (computed_check)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offers one byte after a random gap and holds it until the block takes it. The valid
    // line is lowered only when a gap is drawn, so back-to-back words keep it high.
    task automatic send_byte(input byte_t value);
        int unsigned gap;
        gap = $urandom_range(0, idle_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        sb.parse_byte(value);
        bytes_sent++;
    endtask

    // Sends a complete frame with random payload under the current header setting. When
    // spoil_check is set, the check byte is flipped in at least one bit.
    task automatic send_frame(input byte_t op, input int unsigned plen, input bit spoil_check);
        logic [15:0] flen;
        byte_t sum;
        byte_t value;
        flen = 16'(plen) + LENGTH_OVERHEAD;
        sum  = flen[15:8] ^ flen[7:0] ^ op;
        send_byte(sb.header_first);
        send_byte(sb.header_second);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        send_byte(op);
        repeat (plen)
        begin
            value = byte_t'($urandom);
            sum ^= value;
            send_byte(value);
        end
        if (spoil_check)
            sum ^= byte_t'($urandom_range(1, 255));
        send_byte(sum);
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom));
    endtask

    // Register writes happen only with the parser idle, so the scoreboard copy changes at
    // the same edge as the block's.
    task automatic write_register(input logic [1:0] index, input byte_t value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(index, value);
        @(posedge clk);
    endtask

    // Stops offering bytes, waits for every predicted word, then lets the last byte that
    // makes no word clear the input register.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, so the payload, check and trailer
    // phases see real traffic; the rest is bad lengths, broken headers and line noise.
    task automatic run_random_setting(input int unsigned budget);
        int unsigned start;
        int unsigned choice;
        int unsigned cap;
        int unsigned plen;
        logic [15:0] flen;
        byte_t wrong;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            // Roughly one item in five runs with no idling at all on either side.
            idle_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
            choice = $urandom_range(0, 99);
            if (choice < 70)
            begin
                // Small payloads mostly; now and then anything up to the current limit.
                cap  = (sb.max_payload < 12) ? sb.max_payload : 12;
                plen = ($urandom_range(0, 24) == 0) ? $urandom_range(0, sb.max_payload)
                                                    : $urandom_range(0, cap);
                send_frame(byte_t'($urandom), plen, $urandom_range(0, 3) == 0);
            end
            else if (choice < 80)
            begin
                // Length error: either shorter than the framing itself, just past the
                // payload limit, or anywhere above it.
                send_byte(sb.header_first);
                send_byte(sb.header_second);
                if ($urandom_range(0, 1) == 0)
                    flen = 16'($urandom_range(0, 7));
                else if ($urandom_range(0, 1) == 0)
                    flen = {8'd0, sb.max_payload} + 16'd9;
                else
                    flen = 16'($urandom_range({8'd0, sb.max_payload} + 9, 16'hFFFF));
                send_byte(flen[15:8]);
                send_byte(flen[7:0]);
            end
            else if (choice < 88)
            begin
                // Wrong second header byte. Repeating the first header byte here checks that
                // the rejected byte is not retried as a first header byte; the following
                // second header byte must then be ignored as well.
                if (sb.header_first != sb.header_second && $urandom_range(0, 1) == 0)
                    wrong = sb.header_first;
                else
                    wrong = byte_t'($urandom);
                if (wrong == sb.header_second)
                    wrong = ~sb.header_second;
                send_byte(sb.header_first);
                send_byte(wrong);
                send_byte(sb.header_second);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
            end
        end
    endtask

    // Every accepted result word goes to the scoreboard; input stalls are counted so the
    // summary shows that back-pressure reached the sender.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed.kind           = kind_t'(kind);
            observed.byte_value     = byte_value;
            observed.byte_index     = byte_index;
            observed.opcode         = opcode;
            observed.payload_length = payload_length;
            observed.received_check = received_check;
            observed.computed_check = computed_check;
            sb.check_result(observed);
        end
        if (rst_n && in_valid && !in_ready)
            input_stall_cycles++;
    end

    // Receiver: a random stall before each word, plus one long hold on request so the
    // result register and the input register both fill and in_ready drops.
    initial
    begin
        int unsigned gap;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (long_hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_request = 1'b0;
                long_holds_done++;
            end
            gap = $urandom_range(0, idle_max);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: a hung handshake or a word that never comes ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        sb.report($sformatf("timeout after %0d cycles with %0d words still predicted",
                            cycle_count, sb.pending()));
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        // Opening bytes under the reset setting: both header bytes zero, payload limit 255.
        byte_t opening_bytes[$] = '{
            // Wrong second header byte; the hunt restarts with no word.
            8'h00, 8'hFF,
            // Frame length 7, below the framing overhead: length error.
            8'h00, 8'h00, 8'h00, 8'h07,
            // Frame length 0xFFFF, far above the payload limit: length error.
            8'h00, 8'h00, 8'hFF, 8'hFF,
            // Empty payload: the check byte follows the opcode directly, and it is right.
            8'h00, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hF7, 8'hFF, 8'h00,
            // One payload byte of 0xFF with a bad check byte: payload word, then mismatch.
            8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA
        };
        int unsigned setting;
        byte_t first;
        byte_t second;
        byte_t limit;

        sb = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_HEADER_FIRST;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_ready = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        wait_for_drain();

        for (setting = 0; setting < SETTING_COUNT; setting++)
        begin
            // The first two settings pin the extremes of the payload limit; the rest are
            // random, with the two header bytes sometimes equal.
            case (setting)
                0:
                begin
                    first = 8'hA5;
                    second = 8'h5A;
                    limit = 8'hFF;
                end
                1:
                begin
                    first = 8'hFF;
                    second = 8'h00;
                    limit = 8'h00;
                end
                default:
                begin
                    first = byte_t'($urandom);
                    second = ($urandom_range(0, 3) == 0) ? first : byte_t'($urandom);
                    case ($urandom_range(0, 2))
                        0: limit = byte_t'($urandom_range(1, 40));
                        1: limit = 8'hFF;
                        default: limit = 8'h08;
                    endcase
                end
            endcase
            write_register(REG_HEADER_FIRST, first);
            write_register(REG_HEADER_SECOND, second);
            write_register(REG_MAX_PAYLOAD, limit);
            // A write to the unused index must leave every register as it is.
            if (setting == 0)
                write_register(REG_UNUSED, byte_t'($urandom));

            run_random_setting(RANDOM_BYTES / SETTING_COUNT);

            // Under the widest limit, one frame of the largest payload goes out at full rate
            // while the receiver holds off, so the block backs up into the sender.
            if (setting == 0)
            begin
                idle_max = 0;
                long_hold_request = 1'b1;
                send_frame(byte_t'($urandom), 255, 1'b0);
                idle_max = 10;
            end
            wait_for_drain();
        end

        $display("Run covered %0d input bytes under %0d register settings: %0d payload words,",
                 bytes_sent, SETTING_COUNT + 1, sb.kind_total[KIND_PAYLOAD]);
        $display("%0d good frames, %0d check mismatches, %0d length errors; %0d stall cycles.",
                 sb.kind_total[KIND_GOOD], sb.kind_total[KIND_MISMATCH],
                 sb.kind_total[KIND_LEN_ERROR], input_stall_cycles);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
